FILE: rtl/bfab_pkg.sv
// shared types, constants and helpers for the back-to-front alpha blend block
// used by bfab_ctrl, bfab_dpath and back_to_front_alpha_blend; no dependencies
package bfab_pkg;

    localparam int CHAN_W   = 8;               // one color or alpha channel
    localparam int NUM_CHAN = 3;               // red, green, blue
    localparam int DEN_W    = 2 * CHAN_W;      // coverage term, at most 255*255
    localparam int NUM_W    = 3 * CHAN_W;      // weighted color sum, below 256*den
    localparam int QUO_W    = CHAN_W;          // one quotient bit per divide step
    localparam int CNT_W    = $clog2(QUO_W);
    localparam int PIX_W    = 4 * CHAN_W;      // packed rgba

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the input transaction
        logic weight;    // back weight and coverage
        logic prod;      // per-channel products
        logic start;     // form numerators, arm the dividers
        logic step;      // one restoring divide step
        logic commit;    // update the accumulator
        logic emit;      // load the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;      // the held layer closes the pixel
    } sts_t;

    // floor(x / 255) for x up to 65025
    function automatic logic [CHAN_W-1:0] div255(input logic [DEN_W-1:0] x);
        logic [DEN_W:0] t;
        t = {1'b0, x} + {{(CHAN_W + 1){1'b0}}, x[DEN_W-1:CHAN_W]} + 1'b1;
        return t[DEN_W-1:CHAN_W];
    endfunction

endpackage

FILE: rtl/bfab_ctrl.sv
// sequencer for one layer: weight, products, numerators, eight divide steps, commit
// depends on bfab_pkg for the command and status structs
module bfab_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  bfab_pkg::sts_t sts,
    output bfab_pkg::cmd_t cmd
);
    import bfab_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WEIGHT = 3'd1;
    localparam logic [2:0] S_PROD   = 3'd2;
    localparam logic [2:0] S_LOAD   = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_busy;

    assign out_busy = out_valid_reg && !m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_WEIGHT;
                end
            end
            S_WEIGHT:
            begin
                cmd.weight = 1'b1;
                state_next = S_PROD;
            end
            S_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.start  = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                // a closing layer waits until the output register is free
                if (!(sts.last && out_busy))
                begin
                    cmd.commit = 1'b1;
                    cmd.emit   = sts.last;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.weight, cmd.prod, cmd.start, cmd.step, cmd.commit}))
        else $error("more than one datapath command at once");

    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_WEIGHT))
        else $error("accepted transaction did not start the layer sequence");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == LAST_STEP) |=> (state_reg == S_COMMIT))
        else $error("divide did not end after eight steps");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_busy)
        else $error("result emitted over a stalled output");

endmodule

FILE: rtl/bfab_dpath.sv
// input capture, accumulator, product lanes and three restoring dividers
// depends on bfab_pkg; driven by the command struct from bfab_ctrl
module bfab_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bfab_pkg::PIX_W-1:0]   in_data,
    input  logic                          in_first,
    input  logic                          in_last,
    input  bfab_pkg::cmd_t                cmd,
    output bfab_pkg::sts_t                sts,
    output logic [bfab_pkg::PIX_W-1:0]   out_data
);
    import bfab_pkg::*;

    logic [CHAN_W-1:0] in_color_reg [NUM_CHAN];
    logic [CHAN_W-1:0] in_alpha_reg;
    logic              last_reg;

    logic [CHAN_W-1:0] acc_color_reg [NUM_CHAN];
    logic [CHAN_W-1:0] acc_color_next [NUM_CHAN];
    logic [CHAN_W-1:0] acc_alpha_reg, acc_alpha_next;

    logic [DEN_W-1:0]  back_w_reg, back_w_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  prod_sa_reg [NUM_CHAN];
    logic [NUM_W-1:0]  prod_bw_reg [NUM_CHAN];
    logic [NUM_W-1:0]  rem_reg [NUM_CHAN];
    logic [NUM_W-1:0]  rem_next [NUM_CHAN];
    logic [QUO_W-1:0]  quo_reg [NUM_CHAN];
    logic [QUO_W-1:0]  quo_next [NUM_CHAN];
    logic [NUM_W-1:0]  dvsr_reg;
    logic [PIX_W-1:0]  out_data_reg;

    assign sts.last = last_reg;
    assign out_data = out_data_reg;

    // back weight da*(255-sa), coverage sa*255 + back weight
    always_comb
    begin
        back_w_next = {{CHAN_W{1'b0}}, acc_alpha_reg}
                    * {{CHAN_W{1'b0}}, ~in_alpha_reg};
        den_next    = {in_alpha_reg, {CHAN_W{1'b0}}}
                    - {{CHAN_W{1'b0}}, in_alpha_reg} + back_w_next;
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            rem_next[c] = rem_reg[c];
            quo_next[c] = {quo_reg[c][QUO_W-2:0], 1'b0};
            if (rem_reg[c] >= dvsr_reg)
            begin
                rem_next[c] = rem_reg[c] - dvsr_reg;
                quo_next[c] = {quo_reg[c][QUO_W-2:0], 1'b1};
            end
        end
    end

    // zero coverage keeps the colors
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            acc_color_next[c] = (den_reg != '0) ? quo_reg[c] : acc_color_reg[c];
        end
        acc_alpha_next = div255(den_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                acc_color_reg[c] <= '0;
            end
            acc_alpha_reg <= '0;
        end
        else if (cmd.load && in_first)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                acc_color_reg[c] <= '0;
            end
            acc_alpha_reg <= '0;
        end
        else if (cmd.commit)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                acc_color_reg[c] <= acc_color_next[c];
            end
            acc_alpha_reg <= acc_alpha_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                in_color_reg[c] <= in_data[c*CHAN_W +: CHAN_W];
            end
            in_alpha_reg <= in_data[NUM_CHAN*CHAN_W +: CHAN_W];
            last_reg     <= in_last;
        end
        if (cmd.weight)
        begin
            back_w_reg <= back_w_next;
            den_reg    <= den_next;
        end
        if (cmd.prod)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                prod_sa_reg[c] <= {{CHAN_W{1'b0}}, in_color_reg[c]}
                                * {{CHAN_W{1'b0}}, in_alpha_reg};
                prod_bw_reg[c] <= {{DEN_W{1'b0}}, acc_color_reg[c]}
                                * {{CHAN_W{1'b0}}, back_w_reg};
            end
            // divisor aligned to the top quotient bit
            dvsr_reg <= {den_reg, {(NUM_W - DEN_W){1'b0}}} >> 1;
        end
        if (cmd.start)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                rem_reg[c] <= {prod_sa_reg[c], {CHAN_W{1'b0}}}
                            - {{CHAN_W{1'b0}}, prod_sa_reg[c]} + prod_bw_reg[c];
                quo_reg[c] <= '0;
            end
        end
        if (cmd.step)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                rem_reg[c] <= rem_next[c];
                quo_reg[c] <= quo_next[c];
            end
            dvsr_reg <= dvsr_reg >> 1;
        end
        if (cmd.emit)
        begin
            out_data_reg <= {acc_alpha_next, acc_color_next[2],
                             acc_color_next[1], acc_color_next[0]};
        end
    end

endmodule

FILE: rtl/back_to_front_alpha_blend.sv
// top level of the back-to-front over compositor for rgba8 pixels
// depends on bfab_pkg, bfab_ctrl and bfab_dpath
//
// usage: send the layers of one pixel on the slave stream, back-most first.
// s_tdata carries the layer color and alpha, s_tuser marks the back-most
// layer (the accumulator starts from zero) and s_tlast the front-most layer.
// a transaction with s_tlast set yields one composited pixel on the master
// stream; other layers only update the accumulator.
// layer sequence: accept, weight, product, numerator, the divide steps and
// commit. s_tready stays low from acceptance until the commit is done, so a
// new layer is not taken before the last one is through. the three parallel
// restoring dividers give one quotient bit per cycle over eight steps. the
// output register and m_tvalid of a closing layer are loaded in its commit.
// reset clears the accumulator to zero and drops m_tvalid.
// a stalled receiver holds the result in the output register; the next layer
// is still accepted and processed, and only a following closing layer waits
// in its commit cycle until the held pixel is taken.
module back_to_front_alpha_blend (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bfab_pkg::PIX_W-1:0]  s_tdata,   // layer_red, layer_green, layer_blue, layer_alpha
    input  logic                         s_tuser,   // first_layer
    input  logic                         s_tlast,   // last_layer
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bfab_pkg::PIX_W-1:0]  m_tdata    // out_red, out_green, out_blue, out_alpha
);
    import bfab_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bfab_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bfab_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (s_tdata),
        .in_first (s_tuser),
        .in_last  (s_tlast),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (m_tdata)
    );

endmodule

FILE: tb/sv/back_to_front_alpha_blend_tb.sv
// self-checking testbench for back_to_front_alpha_blend: over-compositing of rgba8 layers
// drives layer transactions, predicts or takes by hand each composited pixel and checks it; needs bfab_pkg
`timescale 1ns / 1ps

module back_to_front_alpha_blend_tb;

    localparam int CW          = bfab_pkg::CHAN_W;
    localparam int ITEM_TARGET = 1350;
    localparam int CYCLE_LIMIT = 600000;
    localparam int IDLE_PCT    = 32;
    localparam int QUIET_FROM  = 600;
    localparam int QUIET_TO    = 800;

    typedef struct {
        logic [CW-1:0] red;
        logic [CW-1:0] green;
        logic [CW-1:0] blue;
        logic [CW-1:0] alpha;
        bit            first;
        bit            last;
    } layer_t;

    typedef struct packed {
        logic [CW-1:0] alpha;
        logic [CW-1:0] blue;
        logic [CW-1:0] green;
        logic [CW-1:0] red;
    } pixel_t;

    typedef struct {
        layer_t layer;
        bit     typed;      // expected pixel given by hand
        pixel_t pix;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [bfab_pkg::PIX_W-1:0] s_tdata = '0;    // layer_red, layer_green, layer_blue, layer_alpha
    logic                       s_tuser = 1'b0;  // first_layer
    logic                       s_tlast = 1'b0;  // last_layer
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [bfab_pkg::PIX_W-1:0] m_tdata;         // out_red, out_green, out_blue, out_alpha

    // predicted accumulator
    logic [CW-1:0] acc_red, acc_green, acc_blue, acc_alpha;

    pixel_t    pending_pixels[$];
    stim_row_t directed_rows[$];
    int        fail_count = 0;
    int        layers_sent = 0;
    int        cycle_count = 0;
    bit        quiet = 1'b0;

    back_to_front_alpha_blend dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [CW-1:0] over_channel(input logic [31:0] src, input logic [31:0] dst,
                                                   input logic [31:0] sa, input logic [31:0] back_w,
                                                   input logic [31:0] den);
        logic [31:0] q;
        q = (src * sa * 255 + dst * back_w) / den;
        return (q > 255) ? CW'(255) : q[CW-1:0];
    endfunction

    // blends one layer over the predicted accumulator, returns the pixel on a closing layer
    task automatic composite_layer(input layer_t l, output bit emit, output pixel_t px);
        logic [31:0] sa;
        logic [31:0] back_w;
        logic [31:0] den;
        sa = 32'(l.alpha);
        if (l.first)
        begin
            acc_red   = '0;
            acc_green = '0;
            acc_blue  = '0;
            acc_alpha = '0;
        end
        back_w = 32'(acc_alpha) * (255 - sa);
        den    = sa * 255 + back_w;
        if (den != 0)
        begin
            acc_red   = over_channel(32'(l.red),   32'(acc_red),   sa, back_w, den);
            acc_green = over_channel(32'(l.green), 32'(acc_green), sa, back_w, den);
            acc_blue  = over_channel(32'(l.blue),  32'(acc_blue),  sa, back_w, den);
        end
        acc_alpha = CW'(den / 255);
        emit = l.last;
        px   = '{alpha: acc_alpha, blue: acc_blue, green: acc_green, red: acc_red};
    endtask

    task automatic send_layer(input layer_t l, input bit typed, input pixel_t typed_pix);
        bit     emit;
        pixel_t px;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {l.alpha, l.blue, l.green, l.red};
        s_tuser  <= l.first;
        s_tlast  <= l.last;
        do
            @(posedge clk);
        while (!s_tready);
        composite_layer(l, emit, px);
        if (emit)
            pending_pixels = {pending_pixels, (typed ? typed_pix : px)};
        layers_sent++;
        quiet = (layers_sent >= QUIET_FROM && layers_sent < QUIET_TO);
        @(negedge clk);
    endtask

    function automatic void add_row(input logic [CW-1:0] r, input logic [CW-1:0] g,
                                    input logic [CW-1:0] b, input logic [CW-1:0] a,
                                    input bit first, input bit last, input bit typed,
                                    input pixel_t px);
        stim_row_t row;
        row.layer = '{red: r, green: g, blue: b, alpha: a, first: first, last: last};
        row.typed = typed;
        row.pix   = px;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic logic [CW-1:0] pick_alpha();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return CW'($urandom_range(1, 15));
            3:       return CW'($urandom_range(240, 254));
            default: return CW'($urandom_range(0, 255));
        endcase
    endfunction

    // receiver with random backpressure, always ready in the quiet window
    always @(negedge clk)
        m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin : check_pixels
        pixel_t want;
        pixel_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel %h, none expected", $time, got);
                fail_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (want.red !== got.red)
                begin
                    $display("%0t: red expected %h actual %h", $time, want.red, got.red);
                    fail_count++;
                end
                if (want.green !== got.green)
                begin
                    $display("%0t: green expected %h actual %h", $time, want.green, got.green);
                    fail_count++;
                end
                if (want.blue !== got.blue)
                begin
                    $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
                    fail_count++;
                end
                if (want.alpha !== got.alpha)
                begin
                    $display("%0t: alpha expected %h actual %h", $time, want.alpha, got.alpha);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        layer_t l;
        pixel_t none;
        int     depth;
        bit     noisy;
        none = '0;

        acc_red   = '0;
        acc_green = '0;
        acc_blue  = '0;
        acc_alpha = '0;

        // r, g, b, a, first, last, typed, expected {a, b, g, r}
        // no first mark straight after reset: zero coverage over the reset value
        add_row(8'd10, 8'd20, 8'd30, 8'h00, 0, 1, 1, '{8'h00, 8'h00, 8'h00, 8'h00});
        // single layers: color passes through, alpha kept; a fully transparent one leaves all zero
        add_row(8'hff, 8'h00, 8'h80, 8'hff, 1, 1, 1, '{8'hff, 8'h80, 8'h00, 8'hff});
        add_row(8'hff, 8'hff, 8'hff, 8'hff, 1, 1, 1, '{8'hff, 8'hff, 8'hff, 8'hff});
        add_row(8'h00, 8'h00, 8'h00, 8'hff, 1, 1, 1, '{8'hff, 8'h00, 8'h00, 8'h00});
        add_row(8'd200, 8'd100, 8'd50, 8'd128, 1, 1, 1, '{8'd128, 8'd50, 8'd100, 8'd200});
        add_row(8'hff, 8'hff, 8'hff, 8'h00, 1, 1, 1, '{8'h00, 8'h00, 8'h00, 8'h00});
        add_row(8'h55, 8'haa, 8'h01, 8'h01, 1, 1, 1, '{8'h01, 8'h01, 8'haa, 8'h55});
        // three-layer stack
        add_row(8'hff, 8'h00, 8'h00, 8'hff, 1, 0, 0, none);
        add_row(8'h00, 8'h00, 8'hff, 8'd128, 0, 0, 0, none);
        add_row(8'h00, 8'hff, 8'h00, 8'h01, 0, 1, 0, none);
        // no first mark after an emitted pixel
        add_row(8'd50, 8'd60, 8'd70, 8'd100, 0, 1, 0, none);
        // zero coverage through a whole pixel
        add_row(8'd1, 8'd2, 8'd3, 8'h00, 1, 0, 0, none);
        add_row(8'd4, 8'd5, 8'd6, 8'h00, 0, 0, 0, none);
        add_row(8'd9, 8'd8, 8'd7, 8'h00, 0, 1, 1, '{8'h00, 8'h00, 8'h00, 8'h00});
        // transparent layer over opaque keeps the back
        add_row(8'd10, 8'd20, 8'd30, 8'hff, 1, 0, 0, none);
        add_row(8'd200, 8'd200, 8'd200, 8'h00, 0, 1, 1, '{8'hff, 8'd30, 8'd20, 8'd10});
        // opaque layer hides the back
        add_row(8'd1, 8'd2, 8'd3, 8'd77, 1, 0, 0, none);
        add_row(8'd4, 8'd5, 8'd6, 8'hff, 0, 1, 1, '{8'hff, 8'd6, 8'd5, 8'd4});
        // faint layers piling up, with one near-opaque layer among them
        add_row(8'hff, 8'hff, 8'hff, 8'h01, 1, 0, 0, none);
        add_row(8'h00, 8'h00, 8'h00, 8'h01, 0, 0, 0, none);
        add_row(8'hff, 8'h00, 8'hff, 8'hfe, 0, 0, 0, none);
        add_row(8'h7f, 8'h80, 8'h7f, 8'h02, 0, 1, 0, none);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_layer(directed_rows[i].layer, directed_rows[i].typed, directed_rows[i].pix);

        while (layers_sent < ITEM_TARGET)
        begin
            depth = $urandom_range(1, 5);
            noisy = ($urandom_range(0, 99) < 15);
            for (int k = 0; k < depth; k++)
            begin
                l.red   = CW'($urandom_range(0, 255));
                l.green = CW'($urandom_range(0, 255));
                l.blue  = CW'($urandom_range(0, 255));
                l.alpha = pick_alpha();
                if (noisy)
                begin
                    l.first = 1'($urandom_range(0, 1));
                    l.last  = 1'($urandom_range(0, 1));
                end
                else
                begin
                    l.first = (k == 0);
                    l.last  = (k == depth - 1);
                end
                send_layer(l, 1'b0, none);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/bfab_pkg.sv
rtl/bfab_ctrl.sv
rtl/bfab_dpath.sv
rtl/back_to_front_alpha_blend.sv
tb/sv/back_to_front_alpha_blend_tb.sv
